/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk_i.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked in reset as well
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/brld_pkg.sv */
// ---------------------------------------------------------------------------
// brld_pkg
// Types and constants of the byte run line decoder.
// ---------------------------------------------------------------------------
package brld_pkg;

  localparam int MaxSide = 512;

  localparam int CfgW  = 10;
  localparam int ColW  = 10;
  localparam int LineW = 9;

  localparam logic [CfgW-1:0] MaxSideC      = CfgW'(MaxSide);
  localparam logic [CfgW-1:0] LineWidthRst  = 10'd320;
  localparam logic [CfgW-1:0] LineCountRst  = 10'd200;

  localparam logic [7:0] HdrNoop = 8'h80;
  localparam logic [7:0] ByteMax = 8'hff;
  localparam logic [7:0] RunBias = 8'd2;

  // register index, from paddr[2]
  localparam logic RegLineWidth = 1'b0;
  localparam logic RegLineCount = 1'b1;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhLiteral = 3'b010,
    PhRepeat  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0]       pixel_index;
    logic [7:0]       run_length;
    logic [ColW-1:0]  start_column;
    logic [LineW-1:0] line_number;
    logic             line_done;
    logic             image_done;
  } rec_t;

endpackage

/* rtl/byte_run_line_decoder.sv */
// ---------------------------------------------------------------------------
// byte_run_line_decoder: PackBits-style image decoder, one code byte a beat.
// A data beat's record is registered into the output stage, or into the skid slot while the output is stalled.
// Throughput: one code beat per cycle while in_stall_o is low; a 2-entry output stage (register+skid).
// Reset: phase to header, counters to zero, width 320, count 200, no records.
// ---------------------------------------------------------------------------
module byte_run_line_decoder
  import brld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_index_o,
  output logic [7:0]  run_length_o,
  output logic [9:0]  start_column_o,
  output logic [8:0]  line_number_o,
  output logic        line_done_o,
  output logic        image_done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CfgW-1:0] line_width_q, line_count_q;

  phase_e           phase_q, phase_d;
  logic [7:0]       lit_left_q, lit_left_d;
  logic [7:0]       rep_len_q, rep_len_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [LineW-1:0] line_q, line_d;

  rec_t out_q, skid_q, rec;
  logic out_valid_q, skid_valid_q;
  logic accept, produce, out_free;

  logic [CfgW-1:0] w_eff, h_eff;
  logic [ColW-1:0] col_new;
  logic [CfgW-1:0] line_inc;
  logic            test_end, line_end, img_end;

  // config port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      RegLineWidth: prdata = {{(32-CfgW){1'b0}}, line_width_q};
      RegLineCount: prdata = {{(32-CfgW){1'b0}}, line_count_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthRst;
      line_count_q <= LineCountRst;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        RegLineWidth: line_width_q <= pwdata[CfgW-1:0];
        RegLineCount: line_count_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // decode
  assign accept = in_valid_i && !in_stall_o;
  assign w_eff  = (line_width_q > MaxSideC) ? MaxSideC : line_width_q;

  always_comb begin
    h_eff = (line_count_q > MaxSideC) ? MaxSideC : line_count_q;
    if (h_eff == '0) begin
      h_eff = CfgW'(1);
    end
  end

  assign line_inc = {1'b0, line_q} + CfgW'(1);

  always_comb begin
    phase_d    = phase_q;
    lit_left_d = lit_left_q;
    rep_len_d  = rep_len_q;
    col_d      = col_q;
    line_d     = line_q;
    produce    = 1'b0;
    test_end   = 1'b0;
    col_new    = col_q;
    rec.pixel_index  = code_byte_i;
    rec.run_length   = 8'd1;
    rec.start_column = col_q;
    rec.line_number  = line_q;
    unique case (phase_q)
      PhLiteral: begin
        produce    = 1'b1;
        col_new    = col_q + ColW'(1);
        lit_left_d = lit_left_q - 8'd1;
        test_end   = (lit_left_q == 8'd1);
        if (test_end) begin
          phase_d = PhHeader;
        end
      end
      PhRepeat: begin
        produce        = 1'b1;
        rec.run_length = rep_len_q;
        col_new        = col_q + ColW'(rep_len_q);
        test_end       = 1'b1;
        phase_d        = PhHeader;
      end
      default: begin
        if (code_byte_i < HdrNoop) begin
          lit_left_d = code_byte_i + 8'd1;
          phase_d    = PhLiteral;
        end else if (code_byte_i > HdrNoop) begin
          rep_len_d = (code_byte_i ^ ByteMax) + RunBias;
          phase_d   = PhRepeat;
        end
      end
    endcase
    line_end = test_end && (col_new >= w_eff);
    img_end  = line_end && (line_inc >= h_eff);
    rec.line_done  = line_end;
    rec.image_done = img_end;
    col_d = col_new;
    if (line_end) begin
      col_d  = '0;
      line_d = img_end ? '0 : line_inc[LineW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      lit_left_q <= '0;
      rep_len_q  <= '0;
      col_q      <= '0;
      line_q     <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      rep_len_q  <= rep_len_d;
      col_q      <= col_d;
      line_q     <= line_d;
    end
  end

  // output register with skid
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept && produce;
      end
    end else if (accept && produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : rec;
    end else if (accept && produce) begin
      skid_q <= rec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_index_o  = out_q.pixel_index;
  assign run_length_o   = out_q.run_length;
  assign start_column_o = out_q.start_column;
  assign line_number_o  = out_q.line_number;
  assign line_done_o    = out_q.line_done;
  assign image_done_o   = out_q.image_done;

endmodule

/* rtl/brld_checker.sv */
// ---------------------------------------------------------------------------
// brld_checker
// Port-level checks of the byte run line decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  pixel_index_o,
  input logic [9:0]  start_column_o,
  input logic        line_done_o,
  input logic        image_done_o
);

  // input only stalls when both output slots hold a beat
  `ASSERT_CLK(a_stall_needs_out, in_stall_o |-> out_valid_o, "stall without pending beat")

  `ASSERT_CLK(a_img_ends_line, out_valid_o && image_done_o |-> line_done_o, "image end w/o line end")

  `ASSERT_CLK_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "not idle after reset")

  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_index_o) && $stable(start_column_o), "stalled beat changed")

endmodule

bind byte_run_line_decoder brld_checker u_brld_checker (.*);
